// ===== hw/rtl/dmpa_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpa_pkg
// Types, codes and sizes shared by the dilated max pool argmax block.
// ----------------------------------------------------------------------------
package dmpa_pkg;

    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int MAX_KERNEL     = 8;
    localparam int STEP_LIMIT     = 8;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 12;
    localparam int POS_W    = 7;
    localparam int KERN_W   = 4;
    localparam int STEP_W   = 4;
    localparam int PAD_W    = 6;
    localparam int DIM_W    = 7;
    localparam int SPAN_W   = 8;
    localparam int COORD_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DILATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } dmpa_state_t;

    typedef struct packed {
        logic                       func;
        logic [POS_W-1:0]           row_pos;
        logic [POS_W-1:0]           col_pos;
        logic signed [SAMPLE_W-1:0] sample_value;
    } dmpa_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] max_value;
        logic [INDEX_W-1:0]         max_index;
        logic [1:0]                 status;
    } dmpa_out_t;

    // effective register values after clamping (pad passes through unclamped)
    typedef struct packed {
        logic [KERN_W-1:0] kernel;
        logic [STEP_W-1:0] step;
        logic [PAD_W-1:0]  pad;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
    } dmpa_cfg_t;

endpackage

// ===== hw/rtl/dmpa_cfg.sv =====
// ----------------------------------------------------------------------------
// dmpa_cfg
// Configuration register file with clamping of the window and plane settings.
// ----------------------------------------------------------------------------
module dmpa_cfg #(
    parameter int MAX_HEIGHT = dmpa_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = dmpa_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dmpa_pkg::dmpa_cfg_t                 cfg_eff
);
    import dmpa_pkg::*;

    logic [KERN_W-1:0] kernel_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PAD_W-1:0]  pad_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= KERN_W'(2);
            step_reg   <= STEP_W'(1);
            pad_reg    <= '0;
            height_reg <= DIM_W'(64);
            width_reg  <= DIM_W'(64);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KERNEL:   kernel_reg <= cfg_data[KERN_W-1:0];
                REG_DILATION: step_reg   <= cfg_data[STEP_W-1:0];
                REG_PAD:      pad_reg    <= cfg_data[PAD_W-1:0];
                REG_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                REG_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_eff.pad = pad_reg;

        if (kernel_reg == '0)
            cfg_eff.kernel = KERN_W'(1);
        else if (int'(kernel_reg) > MAX_KERNEL)
            cfg_eff.kernel = KERN_W'(MAX_KERNEL);
        else
            cfg_eff.kernel = kernel_reg;

        if (step_reg == '0)
            cfg_eff.step = STEP_W'(1);
        else if (int'(step_reg) > STEP_LIMIT)
            cfg_eff.step = STEP_W'(STEP_LIMIT);
        else
            cfg_eff.step = step_reg;

        if (height_reg == '0)
            cfg_eff.height = DIM_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            cfg_eff.height = DIM_W'(MAX_HEIGHT);
        else
            cfg_eff.height = height_reg;

        if (width_reg == '0)
            cfg_eff.width = DIM_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            cfg_eff.width = DIM_W'(MAX_WIDTH);
        else
            cfg_eff.width = width_reg;
    end

endmodule

// ===== hw/rtl/dmpa_plane.sv =====
// ----------------------------------------------------------------------------
// dmpa_plane
// Feature-map plane memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmpa_plane #(
    parameter int MAX_HEIGHT = dmpa_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = dmpa_pkg::DEF_MAX_WIDTH,
    parameter int ROW_AW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    parameter int COL_AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [ROW_AW-1:0]                     wr_row,
    input  logic [COL_AW-1:0]                     wr_col,
    input  logic signed [dmpa_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic [ROW_AW-1:0]                     rd_row,
    input  logic [COL_AW-1:0]                     rd_col,
    output logic signed [dmpa_pkg::SAMPLE_W-1:0]  rd_data
);
    import dmpa_pkg::*;

    localparam int DEPTH = 1 << (ROW_AW + COL_AW);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[{wr_row, wr_col}] <= wr_data;
        rd_data_reg <= mem[{rd_row, rd_col}];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dmpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmpa_ctrl
// Window sequencer with a shared compare unit and the result output register.
// ----------------------------------------------------------------------------
module dmpa_ctrl #(
    parameter int ROW_AW = 6,
    parameter int COL_AW = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dmpa_pkg::dmpa_cfg_t                   cfg_eff,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  dmpa_pkg::dmpa_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output dmpa_pkg::dmpa_out_t                   m_data,
    output logic                                  wr_en,
    output logic [ROW_AW-1:0]                     wr_row,
    output logic [COL_AW-1:0]                     wr_col,
    output logic signed [dmpa_pkg::SAMPLE_W-1:0]  wr_data,
    output logic [ROW_AW-1:0]                     rd_row,
    output logic [COL_AW-1:0]                     rd_col,
    input  logic signed [dmpa_pkg::SAMPLE_W-1:0]  rd_data
);
    import dmpa_pkg::*;

    dmpa_state_t state_reg, state_next;

    logic [POS_W-1:0]            row_reg, row_next;
    logic [POS_W-1:0]            col_reg, col_next;
    logic [SPAN_W-1:0]           span_reg, span_next;
    logic signed [COORD_W-1:0]   hs_reg, hs_next;
    logic signed [COORD_W-1:0]   ws_reg, ws_next;
    logic signed [COORD_W-1:0]   h_reg, h_next;
    logic signed [COORD_W-1:0]   w_reg, w_next;
    logic [KERN_W-1:0]           i_reg, i_next;
    logic [KERN_W-1:0]           j_reg, j_next;
    logic                        pend_reg, pend_next;
    logic [INDEX_W-1:0]          pidx_reg, pidx_next;
    logic                        found_reg, found_next;
    logic signed [SAMPLE_W-1:0]  best_reg, best_next;
    logic [INDEX_W-1:0]          bidx_reg, bidx_next;
    logic                        scan_reg, scan_next;
    logic [1:0]                  stat_reg, stat_next;
    logic                        m_valid_reg, m_valid_next;
    dmpa_out_t                   m_data_reg, m_data_next;

    logic                        s_fire;
    logic                        out_free;
    logic                        store_ok;
    logic                        row_last, col_last;
    logic                        tap_ok;
    logic                        range_bad;
    logic signed [COORD_W-1:0]   pool_h, pool_w;
    logic signed [COORD_W-1:0]   step_s;
    logic [KERN_W-1:0]           k_last;
    dmpa_out_t                   result;

    function automatic logic signed [COORD_W-1:0] pooled_size(
        input logic [DIM_W-1:0]  dim,
        input logic [PAD_W-1:0]  pad,
        input logic [SPAN_W-1:0] span
    );
        logic signed [COORD_W-1:0] n;
        logic signed [COORD_W-1:0] lim;
        n   = $signed(COORD_W'(dim)) + $signed(COORD_W'({pad, 1'b0}))
            - $signed(COORD_W'(span)) + $signed(COORD_W'(1));
        lim = $signed(COORD_W'(dim)) + $signed(COORD_W'(pad));
        if (pad != '0 && (n - $signed(COORD_W'(1))) >= lim)
            n = n - $signed(COORD_W'(1));
        return n;
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign store_ok = (s_data.row_pos < cfg_eff.height) && (s_data.col_pos < cfg_eff.width);
    assign k_last   = cfg_eff.kernel - KERN_W'(1);
    assign row_last = (i_reg == k_last);
    assign col_last = (j_reg == k_last);
    assign step_s   = $signed(COORD_W'(cfg_eff.step));

    assign pool_h    = pooled_size(cfg_eff.height, cfg_eff.pad, span_reg);
    assign pool_w    = pooled_size(cfg_eff.width, cfg_eff.pad, span_reg);
    assign range_bad = ($signed(COORD_W'(row_reg)) >= pool_h)
                    || ($signed(COORD_W'(col_reg)) >= pool_w);

    assign tap_ok = !h_reg[COORD_W-1] && !w_reg[COORD_W-1]
                 && (h_reg < $signed(COORD_W'(cfg_eff.height)))
                 && (w_reg < $signed(COORD_W'(cfg_eff.width)));

    assign wr_en   = s_fire && (s_data.func == FUNC_STORE) && store_ok;
    assign wr_row  = ROW_AW'(s_data.row_pos);
    assign wr_col  = COL_AW'(s_data.col_pos);
    assign wr_data = s_data.sample_value;
    assign rd_row  = ROW_AW'(h_reg);
    assign rd_col  = COL_AW'(w_reg);

    always_comb begin
        result.max_value = SAMPLE_MIN;
        result.max_index = '0;
        result.status    = stat_reg;
        if (scan_reg) begin
            if (found_reg) begin
                result.max_value = best_reg;
                result.max_index = bidx_reg;
                result.status    = STAT_OK;
            end else begin
                result.status    = STAT_EMPTY;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire)
                    state_next = (s_data.func == FUNC_STORE) ? ST_DONE : ST_SETUP;
            end
            ST_SETUP: state_next = ST_CHECK;
            ST_CHECK: state_next = range_bad ? ST_DONE : ST_SCAN;
            ST_SCAN: begin
                if (row_last && col_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        row_next     = row_reg;
        col_next     = col_reg;
        span_next    = span_reg;
        hs_next      = hs_reg;
        ws_next      = ws_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        scan_next    = scan_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        // shared compare unit: first tap taken, later taps only when strictly greater
        if (pend_reg && (!found_reg || rd_data > best_reg)) begin
            found_next = 1'b1;
            best_next  = rd_data;
            bidx_next  = pidx_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    row_next  = s_data.row_pos;
                    col_next  = s_data.col_pos;
                    scan_next = 1'b0;
                    stat_next = (s_data.func == FUNC_STORE && !store_ok) ? STAT_RANGE
                                                                         : STAT_OK;
                end
            end
            ST_SETUP: begin
                span_next = SPAN_W'((SPAN_W'(k_last) * SPAN_W'(cfg_eff.step)) + SPAN_W'(1));
                hs_next   = $signed(COORD_W'(row_reg)) - $signed(COORD_W'(cfg_eff.pad));
                ws_next   = $signed(COORD_W'(col_reg)) - $signed(COORD_W'(cfg_eff.pad));
            end
            ST_CHECK: begin
                if (range_bad) begin
                    stat_next = STAT_RANGE;
                end else begin
                    scan_next  = 1'b1;
                    found_next = 1'b0;
                    h_next     = hs_reg;
                    w_next     = ws_reg;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_SCAN: begin
                pend_next = tap_ok;
                pidx_next = INDEX_W'((2*DIM_W)'(h_reg[DIM_W-1:0]) * (2*DIM_W)'(cfg_eff.width)
                                     + (2*DIM_W)'(w_reg[DIM_W-1:0]));
                if (col_last) begin
                    j_next = '0;
                    w_next = ws_reg;
                    i_next = i_reg + KERN_W'(1);
                    h_next = h_reg + step_s;
                end else begin
                    j_next = j_reg + KERN_W'(1);
                    w_next = w_reg + step_s;
                end
            end
            ST_DRAIN: ;
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            scan_reg    <= 1'b0;
            stat_reg    <= STAT_OK;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            scan_reg    <= scan_next;
            stat_reg    <= stat_next;
        end
        row_reg    <= row_next;
        col_reg    <= col_next;
        span_reg   <= span_next;
        hs_reg     <= hs_next;
        ws_reg     <= ws_next;
        h_reg      <= h_next;
        w_reg      <= w_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        pidx_reg   <= pidx_next;
        best_reg   <= best_next;
        bidx_reg   <= bidx_next;
        m_data_reg <= m_data_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted while an item is in flight");

    a_pend_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg == ST_SCAN))
        else $error("compare issued outside the window scan");

    a_tap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (i_reg <= k_last && j_reg <= k_last))
        else $error("tap counter beyond kernel size");

    a_fail_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_OK)
            |-> (m_data.max_value == SAMPLE_MIN && m_data.max_index == '0))
        else $error("failed result carries a value");

endmodule

// ===== hw/rtl/dilated_max_pool_argmax_top.sv =====
// ----------------------------------------------------------------------------
// dilated_max_pool_argmax_top
// Dilated max pooling with argmax over one stored feature-map plane.
// ----------------------------------------------------------------------------
//  channel  handshake              payload       role
//  s_       s_valid / s_ready      dmpa_in_t     store sample or pooled query
//  m_       m_valid / m_ready      dmpa_out_t    max value, flat index, status
//  cfg_     cfg_valid / cfg_ready  index, data   window and plane registers
//
//  A store goes from idle to the result state. A query steps through setup,
//  check, scan, drain and result, reading one window tap per cycle through
//  the single plane read port; queries outside pooled size skip scan/drain.
//  Synchronous active-low reset clears control state; plane contents are
//  undefined until written. The result register holds a finished transfer
//  while m_ready is low; s_ready rises once that result is handed to it.
// ----------------------------------------------------------------------------
module dilated_max_pool_argmax_top #(
    parameter int MAX_HEIGHT = dmpa_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = dmpa_pkg::DEF_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dmpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dmpa_pkg::dmpa_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dmpa_pkg::dmpa_out_t              m_data
);
    import dmpa_pkg::*;

    localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    dmpa_cfg_t                  cfg_eff;
    logic                       wr_en;
    logic [ROW_AW-1:0]          wr_row;
    logic [COL_AW-1:0]          wr_col;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic [ROW_AW-1:0]          rd_row;
    logic [COL_AW-1:0]          rd_col;
    logic signed [SAMPLE_W-1:0] rd_data;

    dmpa_cfg #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_eff   (cfg_eff)
    );

    dmpa_plane #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .ROW_AW     (ROW_AW),
        .COL_AW     (COL_AW)
    ) u_plane (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_col  (wr_col),
        .wr_data (wr_data),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

    dmpa_ctrl #(
        .ROW_AW (ROW_AW),
        .COL_AW (COL_AW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_eff (cfg_eff),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_col  (wr_col),
        .wr_data (wr_data),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dilated_max_pool_argmax_top. A short directed table
// of stores and pooled queries is followed by randomized phases under varied
// window and plane settings; each result is scored against its table entry
// or an in-bench pooling model tracking the plane contents and register state.
// ----------------------------------------------------------------------------
module testbench;
    import dmpa_pkg::*;

    localparam int PLANE_WORDS = DEF_MAX_HEIGHT * DEF_MAX_WIDTH;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 125;
    localparam int QUIET_PHASE = 4;
    localparam int SETTLE_WAIT = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 100;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        dmpa_in_t              item;
        logic                  typed;
        dmpa_out_t             want;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    dmpa_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    dmpa_out_t             m_data;

    bit          quiet          = 1'b0;
    int unsigned cycle_count    = 0;
    int          mismatch_count = 0;
    int          result_count   = 0;

    dmpa_out_t pending_results[$];
    plan_row_t directed_plan[$];

    logic signed [SAMPLE_W-1:0] plane_model [0:PLANE_WORDS-1];
    bit                         plane_written [0:PLANE_WORDS-1];

    logic [KERN_W-1:0] reg_kernel = 4'd2;
    logic [STEP_W-1:0] reg_step   = 4'd1;
    logic [PAD_W-1:0]  reg_pad    = '0;
    logic [DIM_W-1:0]  reg_height = 7'd64;
    logic [DIM_W-1:0]  reg_width  = 7'd64;
    int eff_kernel, eff_step, eff_pad, eff_height, eff_width, eff_span;

    dilated_max_pool_argmax_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 28);
    end

    function automatic int clamp_setting(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void refresh_effective();
        eff_kernel = clamp_setting(reg_kernel, MAX_KERNEL);
        eff_step   = clamp_setting(reg_step, STEP_LIMIT);
        eff_pad    = reg_pad;
        eff_height = clamp_setting(reg_height, DEF_MAX_HEIGHT);
        eff_width  = clamp_setting(reg_width, DEF_MAX_WIDTH);
        eff_span   = (eff_kernel - 1) * eff_step + 1;
    endfunction

    function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_KERNEL:   reg_kernel = val[KERN_W-1:0];
            REG_DILATION: reg_step   = val[STEP_W-1:0];
            REG_PAD:      reg_pad    = val[PAD_W-1:0];
            REG_HEIGHT:   reg_height = val[DIM_W-1:0];
            REG_WIDTH:    reg_width  = val[DIM_W-1:0];
            default: ;
        endcase
        refresh_effective();
    endfunction

    function automatic int pooled_len(input int dim);
        int n;
        n = dim + 2 * eff_pad - eff_span + 1;
        if (eff_pad != 0 && n - 1 >= dim + eff_pad) n--;
        return n;
    endfunction

    // step the window start forward and its end back into the plane
    function automatic void tap_range(input int pos, input int dim,
                                      output int lo, output int hi);
        lo = pos - eff_pad;
        hi = lo + eff_span;
        while (lo < 0) lo += eff_step;
        while (hi > dim) hi -= eff_step;
    endfunction

    function automatic bit missing_tap(input int row, input int col,
                                       output int mr, output int mc);
        int r0, r1, c0, c1;
        tap_range(row, eff_height, r0, r1);
        tap_range(col, eff_width, c0, c1);
        mr = 0;
        mc = 0;
        for (int h = r0; h < r1; h += eff_step) begin
            for (int w = c0; w < c1; w += eff_step) begin
                if (!plane_written[h * DEF_MAX_WIDTH + w]) begin
                    mr = h;
                    mc = w;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic dmpa_out_t make_result(input int value, input int index,
                                              input logic [1:0] stat);
        dmpa_out_t r;
        r.max_value = value[SAMPLE_W-1:0];
        r.max_index = index[INDEX_W-1:0];
        r.status    = stat;
        return r;
    endfunction

    function automatic dmpa_out_t predict_pool(input dmpa_in_t it);
        int row, col, r0, r1, c0, c1, addr, best_index;
        logic signed [SAMPLE_W-1:0] best;
        bit found;
        row = it.row_pos;
        col = it.col_pos;
        if (it.func == FUNC_STORE) begin
            if (row >= eff_height || col >= eff_width)
                return make_result(SAMPLE_MIN, 0, STAT_RANGE);
            plane_model[row * DEF_MAX_WIDTH + col]   = it.sample_value;
            plane_written[row * DEF_MAX_WIDTH + col] = 1'b1;
            return make_result(SAMPLE_MIN, 0, STAT_OK);
        end
        if (row >= pooled_len(eff_height) || col >= pooled_len(eff_width))
            return make_result(SAMPLE_MIN, 0, STAT_RANGE);
        tap_range(row, eff_height, r0, r1);
        tap_range(col, eff_width, c0, c1);
        found = 1'b0;
        best = SAMPLE_MIN;
        best_index = 0;
        for (int h = r0; h < r1; h += eff_step) begin
            for (int w = c0; w < c1; w += eff_step) begin
                addr = h * DEF_MAX_WIDTH + w;
                if (!found || plane_model[addr] > best) begin
                    found = 1'b1;
                    best = plane_model[addr];
                    best_index = h * eff_width + w;
                end
            end
        end
        if (!found) return make_result(SAMPLE_MIN, 0, STAT_EMPTY);
        return make_result(best, best_index, STAT_OK);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int t;
        case ($urandom_range(0, 9))
            0: t = 32767;
            1: t = -32768;
            2, 3, 4: t = int'($urandom_range(0, 4)) - 2;
            default: t = $urandom;
        endcase
        return t[SAMPLE_W-1:0];
    endfunction

    // queries that would touch an unwritten entry become a store to it
    function automatic dmpa_in_t random_item();
        dmpa_in_t it;
        int rows, cols, r, c, mr, mc;
        it.sample_value = random_sample();
        if ($urandom_range(0, 99) < 35) begin
            it.func = FUNC_STORE;
            rows = eff_height;
            cols = eff_width;
        end else begin
            it.func = FUNC_QUERY;
            rows = pooled_len(eff_height);
            cols = pooled_len(eff_width);
        end
        if (rows < 1 || cols < 1 || $urandom_range(0, 99) < 8) begin
            r = $urandom_range(0, 127);
            c = $urandom_range(0, 127);
        end else begin
            r = $urandom_range(0, (rows > 128 ? 128 : rows) - 1);
            c = $urandom_range(0, (cols > 128 ? 128 : cols) - 1);
        end
        if (it.func == FUNC_QUERY && r < rows && c < cols && missing_tap(r, c, mr, mc)) begin
            it.func = FUNC_STORE;
            r = mr;
            c = mc;
        end
        it.row_pos = r[POS_W-1:0];
        it.col_pos = c[POS_W-1:0];
        return it;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return $urandom_range(65, 127);
            2, 3: return $urandom_range(17, 64);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic int high_bits(input int lsb);
        if ($urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, (1 << (CFG_DATA_W - lsb)) - 1) << lsb;
    endfunction

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_index = idx;
        r.reg_value = val[CFG_DATA_W-1:0];
        directed_plan.push_back(r);
    endfunction

    function automatic void plan_item(input logic f, input int row, input int col,
                                      input int val, input bit typed, input int want_value,
                                      input int want_index, input logic [1:0] want_status);
        plan_row_t r;
        r = '0;
        r.item.func = f;
        r.item.row_pos = row[POS_W-1:0];
        r.item.col_pos = col[POS_W-1:0];
        r.item.sample_value = val[SAMPLE_W-1:0];
        r.typed = typed;
        r.want = make_result(want_value, want_index, want_status);
        directed_plan.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("result %0d: %0s got %0d, expected %0d", result_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        note_reg_write(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic send_item(input dmpa_in_t it, input bit typed, input dmpa_out_t want);
        dmpa_out_t predicted;
        if (!quiet && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_pool(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic program_phase(input int phase);
        int k, s, p, h, w, spn;
        case (phase)
            0: begin
                k = MAX_KERNEL; s = STEP_LIMIT; p = 0;
                h = DEF_MAX_HEIGHT; w = DEF_MAX_WIDTH;
            end
            1: begin
                k = 0; s = 1; p = 0; h = 0; w = 1;
            end
            2: begin
                k = 15; s = 15; p = 63; h = 127; w = 0;
            end
            default: begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
                h = pick_dim();
                w = pick_dim();
                spn = (clamp_setting(k, MAX_KERNEL) - 1) * clamp_setting(s, STEP_LIMIT) + 1;
                if ($urandom_range(0, 9) == 0)
                    p = $urandom_range(0, 63);
                else
                    p = $urandom_range(0, spn > 64 ? 63 : spn - 1);
                k |= high_bits(KERN_W);
                s |= high_bits(STEP_W);
                p |= high_bits(PAD_W);
            end
        endcase
        settle();
        write_reg(REG_KERNEL, k);
        write_reg(REG_DILATION, s);
        write_reg(REG_PAD, p);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : score_results
        dmpa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending, status", m_data.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_data.max_value !== want.max_value)
                    report_mismatch("max_value", m_data.max_value, want.max_value);
                if (m_data.max_index !== want.max_index)
                    report_mismatch("max_index", m_data.max_index, want.max_index);
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[dilated_max_pool_argmax_top] ERROR");
        $finish;
    end

    initial begin
        plan_row_t row;
        bit reg_open;
        refresh_effective();

        // reset settings: 2x2 window, step 1, no padding, 64x64 plane
        plan_item(FUNC_STORE,   0,   0,  32767, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,   0,   1, -32768, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,   1,   0,      0, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,   1,   1,     -1, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,  63,  63,   1234, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,  64,   0,  21845, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_STORE,   0, 127, -21846, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_STORE, 127, 127,      0, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_QUERY,   0,   0,     -1, 1'b1, 32767,      0, STAT_OK);
        plan_item(FUNC_QUERY,  63,   0,      0, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_QUERY, 127, 127,      0, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_STORE,   0,   0,     -1, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,   1,   0,     -1, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_QUERY,   0,   0,      0, 1'b1, -1,         0, STAT_OK);
        // padding wider than the span on a 4x4 plane
        plan_reg(REG_KERNEL, 1);
        plan_reg(REG_DILATION, 1);
        plan_reg(REG_PAD, 2);
        plan_reg(REG_HEIGHT, 4);
        plan_reg(REG_WIDTH, 4);
        plan_item(FUNC_QUERY,   0,   0,      0, 1'b1, SAMPLE_MIN, 0, STAT_EMPTY);
        plan_item(FUNC_QUERY,   2,   2,      0, 1'b1, -1,         0, STAT_OK);
        plan_item(FUNC_QUERY,   3,   3,      0, 1'b0, 0,          0, STAT_OK);
        plan_item(FUNC_QUERY,   6,   6,      0, 1'b1, SAMPLE_MIN, 0, STAT_EMPTY);
        plan_item(FUNC_QUERY,   7,   0,      0, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_STORE,   4,   0,      5, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        // dilated taps all fall outside a 1x1 plane
        plan_reg(REG_KERNEL, 2);
        plan_reg(REG_DILATION, 8);
        plan_reg(REG_PAD, 7);
        plan_reg(REG_HEIGHT, 1);
        plan_reg(REG_WIDTH, 1);
        plan_item(FUNC_QUERY,   0,   0,      0, 1'b1, SAMPLE_MIN, 0, STAT_EMPTY);
        plan_item(FUNC_QUERY,   6,   6,      0, 1'b1, SAMPLE_MIN, 0, STAT_EMPTY);
        // register values beyond their ranges, and an unmapped index
        plan_reg(REG_KERNEL, 15);
        plan_reg(REG_DILATION, 0);
        plan_reg(REG_PAD, 0);
        plan_reg(REG_HEIGHT, 127);
        plan_reg(REG_WIDTH, 0);
        plan_reg(REG_UNUSED, 127);
        plan_item(FUNC_STORE,   5,   0,    777, 1'b1, SAMPLE_MIN, 0, STAT_OK);
        plan_item(FUNC_STORE,   0,   1,      7, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);
        plan_item(FUNC_QUERY,   0,   0,      0, 1'b1, SAMPLE_MIN, 0, STAT_RANGE);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        reg_open = 1'b0;
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_reg) begin
                if (!reg_open) settle();
                write_reg(row.reg_index, row.reg_value);
                reg_open = 1'b1;
            end else begin
                if (reg_open) cfg_valid <= 1'b0;
                reg_open = 1'b0;
                send_item(row.item, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            program_phase(ph);
            quiet = (ph == QUIET_PHASE);
            repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
        end
        quiet = 1'b0;

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[dilated_max_pool_argmax_top] OK");
        else
            $display("[dilated_max_pool_argmax_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/dmpa_pkg.sv
hw/rtl/dmpa_cfg.sv
hw/rtl/dmpa_plane.sv
hw/rtl/dmpa_ctrl.sv
hw/rtl/dilated_max_pool_argmax_top.sv
test/testbench.sv
